FILE: rtl/core/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, symbol codes and the Morse lookup table for the encoder.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [2:0] SYM_DOT     = 3'd0;
	localparam logic [2:0] SYM_DASH    = 3'd1;
	localparam logic [2:0] SYM_CHARGAP = 3'd2;
	localparam logic [2:0] SYM_WORDGAP = 3'd3;
	localparam logic [2:0] SYM_MSGEND  = 3'd4;

	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [5:0] DIGIT_BASE = 6'd26;

	// Pattern bits are sent from bit 0 upward; a set bit is a dash.
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] dashes;
	} morse_t;

	// One queued piece of work: the symbols that one item causes, in order.
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] dashes;
		logic       chargap;
		logic       wordgap;
		logic       msgend;
	} job_t;

	function automatic morse_t morse_lookup(input logic [5:0] idx);
		morse_t m;
		unique case (idx)
			6'd0:  m = '{3'd2, 5'b00010};
			6'd1:  m = '{3'd4, 5'b00001};
			6'd2:  m = '{3'd4, 5'b00101};
			6'd3:  m = '{3'd3, 5'b00001};
			6'd4:  m = '{3'd1, 5'b00000};
			6'd5:  m = '{3'd4, 5'b00100};
			6'd6:  m = '{3'd3, 5'b00011};
			6'd7:  m = '{3'd4, 5'b00000};
			6'd8:  m = '{3'd2, 5'b00000};
			6'd9:  m = '{3'd4, 5'b01110};
			6'd10: m = '{3'd3, 5'b00101};
			6'd11: m = '{3'd4, 5'b00010};
			6'd12: m = '{3'd2, 5'b00011};
			6'd13: m = '{3'd2, 5'b00001};
			6'd14: m = '{3'd3, 5'b00111};
			6'd15: m = '{3'd4, 5'b00110};
			6'd16: m = '{3'd4, 5'b01011};
			6'd17: m = '{3'd3, 5'b00010};
			6'd18: m = '{3'd3, 5'b00000};
			6'd19: m = '{3'd1, 5'b00001};
			6'd20: m = '{3'd3, 5'b00100};
			6'd21: m = '{3'd4, 5'b01000};
			6'd22: m = '{3'd3, 5'b00110};
			6'd23: m = '{3'd4, 5'b01001};
			6'd24: m = '{3'd4, 5'b01101};
			6'd25: m = '{3'd4, 5'b00011};
			6'd26: m = '{3'd5, 5'b11111};
			6'd27: m = '{3'd5, 5'b11110};
			6'd28: m = '{3'd5, 5'b11100};
			6'd29: m = '{3'd5, 5'b11000};
			6'd30: m = '{3'd5, 5'b10000};
			6'd31: m = '{3'd5, 5'b00000};
			6'd32: m = '{3'd5, 5'b00001};
			6'd33: m = '{3'd5, 5'b00011};
			6'd34: m = '{3'd5, 5'b00111};
			6'd35: m = '{3'd5, 5'b01111};
			default: m = '{3'd0, 5'b00000};
		endcase
		return m;
	endfunction

	function automatic logic job_empty(input job_t j);
		return (j.len == 3'd0) && !j.chargap && !j.wordgap && !j.msgend;
	endfunction

endpackage

FILE: rtl/core/mse_char_if.sv
// ----------------------------------------------------------------------------
// mse_char_if
// Channel for message text: one byte and an end-of-message flag per item.
// ----------------------------------------------------------------------------
interface mse_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_message;

	modport source (output valid, output char_code, output end_of_message, input ready);
	modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

FILE: rtl/core/mse_sym_if.sv
// ----------------------------------------------------------------------------
// mse_sym_if
// Channel for Morse symbols: one symbol code and a last flag per item.
// ----------------------------------------------------------------------------
interface mse_sym_if;
	logic       valid;
	logic       ready;
	logic [2:0] symbol;
	logic       last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink   (input valid, input symbol, input last, output ready);
endinterface

FILE: rtl/core/morse_symbol_encoder.sv
// ----------------------------------------------------------------------------
// morse_symbol_encoder
// International Morse code encoder: text bytes in, dot/dash/gap symbols out.
//
//   channel   dir  payload                           per item
//   text      in   char_code[7:0], end_of_message    one message byte
//   symbols   out  symbol[2:0], last                 one Morse symbol
//
// A byte causes zero to eight symbols; the back sequencer sends one symbol
// per cycle while the output is taken, so a letter or digit of n elements
// causes n+1 symbols (plus two at message end). A delimiter that closes a
// word or ends a message causes one or two symbols. The front takes a byte
// per cycle while the two-entry job queue has room. A delimiter that causes
// no symbol is never queued. Reset clears the open-word flag, the queue
// and the output register. Either side may stall without losing items.
// ----------------------------------------------------------------------------
module morse_symbol_encoder
	import mse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mse_char_if.sink  text,
	mse_sym_if.source symbols
);

	logic push, pop, q_ready, q_valid;
	job_t push_job, pop_job;

	mse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.q_ready  (q_ready),
		.push     (push),
		.push_job (push_job)
	);

	mse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.q_ready  (q_ready),
		.pop      (pop),
		.q_valid  (q_valid),
		.pop_job  (pop_job)
	);

	mse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.pop_job (pop_job),
		.pop     (pop),
		.symbols (symbols)
	);

endmodule

FILE: rtl/core/mse_front.sv
// ----------------------------------------------------------------------------
// mse_front
// Accepts text bytes, classifies them and tracks whether a word is open.
// ----------------------------------------------------------------------------
module mse_front
	import mse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mse_char_if.sink   text,
	input  logic       q_ready,
	output logic       push,
	output job_t       push_job
);

	logic       inside_word_q;
	logic       is_lower, is_upper, is_digit, is_alnum;
	logic [5:0] idx;
	morse_t     code;
	logic       accept;

	assign is_lower = (text.char_code >= CH_LOWER_A) && (text.char_code <= CH_LOWER_Z);
	assign is_upper = (text.char_code >= CH_UPPER_A) && (text.char_code <= CH_UPPER_Z);
	assign is_digit = (text.char_code >= CH_DIGIT_0) && (text.char_code <= CH_DIGIT_9);
	assign is_alnum = is_lower || is_upper || is_digit;

	always_comb begin
		if (is_lower) begin
			idx = 6'(text.char_code - CH_LOWER_A);
		end else if (is_upper) begin
			idx = 6'(text.char_code - CH_UPPER_A);
		end else begin
			idx = DIGIT_BASE + 6'(text.char_code - CH_DIGIT_0);
		end
	end

	assign code = morse_lookup(idx);

	always_comb begin
		push_job.len     = is_alnum ? code.len : 3'd0;
		push_job.dashes  = is_alnum ? code.dashes : 5'd0;
		push_job.chargap = is_alnum;
		// A letter or digit closes its own word only at message end; a
		// delimiter closes an open word whether or not the message ends.
		push_job.wordgap = is_alnum ? text.end_of_message : inside_word_q;
		push_job.msgend  = text.end_of_message;
	end

	assign text.ready = q_ready;
	assign accept     = text.valid && text.ready;
	assign push       = accept && !job_empty(push_job);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_word_q <= 1'b0;
		end else if (accept) begin
			inside_word_q <= is_alnum && !text.end_of_message;
		end
	end

	ap_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !job_empty(push_job))
		else $error("front pushed an empty item");

endmodule

FILE: rtl/core/mse_queue.sv
// ----------------------------------------------------------------------------
// mse_queue
// Short flip-flop queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module mse_queue
	import mse_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic q_ready,
	input  logic pop,
	output logic q_valid,
	output job_t pop_job
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_ready = (count_q != QCNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign pop_job = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> q_ready)
		else $error("queue written while full");

	ap_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue read while empty");

endmodule

FILE: rtl/core/mse_back.sv
// ----------------------------------------------------------------------------
// mse_back
// Symbol sequencer: plays out a job a symbol per cycle, unless the output stalls.
// ----------------------------------------------------------------------------
module mse_back
	import mse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_t      pop_job,
	output logic      pop,
	mse_sym_if.source symbols
);

	job_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] out_sym_q;
	logic       out_last_q;
	logic       out_valid_q;

	job_t       rem;
	logic [2:0] next_sym;
	logic       advance;
	logic       done;

	// Pick the next symbol and what is left of the job after it.
	always_comb begin
		rem      = cur_q;
		next_sym = SYM_MSGEND;
		if (cur_q.len != 3'd0) begin
			next_sym   = cur_q.dashes[0] ? SYM_DASH : SYM_DOT;
			rem.dashes = {1'b0, cur_q.dashes[4:1]};
			rem.len    = cur_q.len - 3'd1;
		end else if (cur_q.chargap) begin
			next_sym    = SYM_CHARGAP;
			rem.chargap = 1'b0;
		end else if (cur_q.wordgap) begin
			next_sym    = SYM_WORDGAP;
			rem.wordgap = 1'b0;
		end else begin
			next_sym   = SYM_MSGEND;
			rem.msgend = 1'b0;
		end
	end

	assign done    = job_empty(rem);
	assign advance = cur_valid_q && (!out_valid_q || symbols.ready);
	assign pop     = q_valid && (!cur_valid_q || (advance && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (advance && done) begin
				cur_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (symbols.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_job;
		end else if (advance) begin
			cur_q <= rem;
		end
		if (advance) begin
			out_sym_q  <= next_sym;
			out_last_q <= done;
		end
	end

	assign symbols.valid  = out_valid_q;
	assign symbols.symbol = out_sym_q;
	assign symbols.last   = out_last_q;

	ap_cur_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> !job_empty(cur_q))
		else $error("sequencer holds an empty job");

	ap_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("symbol lost after advance");

endmodule
